// ----- rtl/core/fsa_pkg.sv -----
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared types, constants and fixed-point helpers for the Forth stack ALU.
// ----------------------------------------------------------------------------
package fsa_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned FRAC_BITS   = 32;
  localparam int unsigned AW          = $clog2(STACK_DEPTH);
  localparam int unsigned CW          = $clog2(STACK_DEPTH + 1);
  localparam int unsigned QDEPTH      = 2;
  localparam int unsigned QAW         = $clog2(QDEPTH);

  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] FX_ONE   = 64'd1 << FRAC_BITS;
  localparam logic [7:0]  CHAR_NL  = 8'd10;

  typedef enum logic [4:0] {
    CMD_PUSH  = 5'd0,
    CMD_ADD   = 5'd1,
    CMD_SUB   = 5'd2,
    CMD_MUL   = 5'd3,
    CMD_DIV   = 5'd4,
    CMD_MOD   = 5'd5,
    CMD_LT    = 5'd6,
    CMD_GT    = 5'd7,
    CMD_EQ    = 5'd8,
    CMD_PRINT = 5'd9,
    CMD_DROP  = 5'd10,
    CMD_DUP   = 5'd11,
    CMD_SWAP  = 5'd12,
    CMD_ROT   = 5'd13,
    CMD_OVER  = 5'd14,
    CMD_EMIT  = 5'd15,
    CMD_CR    = 5'd16
  } fsa_cmd_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_DIV0  = 2'd1,
    ERR_UNDER = 2'd2,
    ERR_OVER  = 2'd3
  } fsa_err_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_NUM  = 2'd1,
    KIND_CHAR = 2'd2
  } fsa_kind_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_RDA,
    BK_RDB,
    BK_RDC,
    BK_MUL,
    BK_MULSAT,
    BK_DIV,
    BK_DIVFIN,
    BK_WR,
    BK_DONE
  } fsa_state_e;

  // Classified request handed from front to back
  typedef struct packed {
    logic [4:0]  cmd;
    logic        known;
    logic [1:0]  need;
    logic        grows;
    logic [63:0] lit;
  } fsa_item_t;

  function automatic logic [63:0] fx_mag(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] fx_int_mag(input logic [63:0] v);
    return fx_mag(v) >> FRAC_BITS;
  endfunction

  // Saturate a signed 128-bit magnitude to the 64-bit signed range
  function automatic logic [63:0] fx_sat(input logic [63:0] hi, input logic [63:0] lo,
                                         input logic neg);
    logic [63:0] r;
    if (neg) begin
      r = ((hi != 64'd0) || (lo > SIGN_BIT)) ? SIGN_BIT : (64'd0 - lo);
    end else begin
      r = ((hi != 64'd0) || (lo > MAX_POS)) ? MAX_POS : lo;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/fsa_ram.sv -----
// ----------------------------------------------------------------------------
// fsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fsa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/core/fsa_front.sv -----
// ----------------------------------------------------------------------------
// fsa_front
// Accepts requests, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module fsa_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [4:0]        command_i,
  input  logic [63:0]       literal_i,
  output logic              item_valid_o,
  output fsa_pkg::fsa_item_t item_o,
  input  logic              item_pop_i
);

  fsa_pkg::fsa_item_t       slot_q [fsa_pkg::QDEPTH];
  fsa_pkg::fsa_item_t       cls;
  logic [fsa_pkg::QAW-1:0]  wptr_q, rptr_q;
  logic [fsa_pkg::QAW:0]    fill_q;
  logic                     push, pop;

  // Classify: operand need, growth, known code
  always_comb begin
    cls       = '0;
    cls.cmd   = command_i;
    cls.lit   = literal_i;
    cls.known = (command_i <= fsa_pkg::CMD_CR);
    cls.grows = (command_i == fsa_pkg::CMD_PUSH) || (command_i == fsa_pkg::CMD_DUP) ||
                (command_i == fsa_pkg::CMD_OVER);
    case (command_i) inside
      [fsa_pkg::CMD_ADD:fsa_pkg::CMD_EQ], fsa_pkg::CMD_SWAP, fsa_pkg::CMD_OVER:
        cls.need = 2'd2;
      fsa_pkg::CMD_PRINT, fsa_pkg::CMD_DROP, fsa_pkg::CMD_DUP, fsa_pkg::CMD_EMIT:
        cls.need = 2'd1;
      fsa_pkg::CMD_ROT:
        cls.need = 2'd3;
      default:
        cls.need = 2'd0;
    endcase
  end

  assign in_stall_o   = (fill_q == (fsa_pkg::QAW + 1)'(fsa_pkg::QDEPTH));
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (fill_q != '0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = slot_q[rptr_q];

  // Queue pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + 1'b1;
      if (pop)  rptr_q <= rptr_q + 1'b1;
      fill_q <= fill_q + (fsa_pkg::QAW + 1)'(push) - (fsa_pkg::QAW + 1)'(pop);
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wptr_q] <= cls;
  end

endmodule

// ----- rtl/core/fsa_back.sv -----
// ----------------------------------------------------------------------------
// fsa_back
// Executes queued words against the stack RAM; iterative multiply and divide.
// ----------------------------------------------------------------------------
module fsa_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  fsa_pkg::fsa_item_t item_i,
  output logic               item_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         out_kind_o,
  output logic [63:0]        out_number_o,
  output logic [7:0]         out_char_o,
  output logic [1:0]         error_o,
  output logic [6:0]         depth_now_o
);

  localparam int unsigned AW = fsa_pkg::AW;
  localparam int unsigned CW = fsa_pkg::CW;

  fsa_pkg::fsa_state_e state_q, state_d;
  fsa_pkg::fsa_cmd_e   cmd_q;
  logic [63:0]  lit_q, a_q, b_q, c_q, x_q, y_q, pp_q, res_val_q, res_num_q;
  logic [63:0]  den_q, rem_q, rdata, wdata;
  logic [127:0] acc_q, num_q, quo_q, acc_sh, ppw;
  logic [CW-1:0] cnt_q, res_cnt_q, cm1, cm2, cm3;
  logic [6:0]   step_q;
  logic [1:0]   psel_q;
  logic         neg_q, we, last_wr, under, over, am_zero, out_load, ge;
  logic         go, is_cr, is_push, is_mod;
  logic [AW-1:0] raddr, waddr;
  logic [1:0]   res_kind_q, res_err_q;
  logic [7:0]   res_char_q;
  logic [31:0]  xs, ys;
  logic [63:0]  prod, ipa, rm;
  logic [64:0]  rw, rsub;
  logic         out_valid_q;
  logic [1:0]   out_kind_q, out_err_q;
  logic [63:0]  out_num_q;
  logic [7:0]   out_char_q;
  logic [6:0]   out_depth_q;

  fsa_ram #(.WIDTH(64), .DEPTH(fsa_pkg::STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign cm1     = cnt_q - CW'(1);
  assign cm2     = cnt_q - CW'(2);
  assign cm3     = cnt_q - CW'(3);
  assign under   = (cnt_q < CW'(item_i.need));
  assign over    = item_i.grows && (cnt_q >= CW'(fsa_pkg::STACK_DEPTH));
  assign am_zero = (fsa_pkg::fx_int_mag(a_q) == 64'd0);
  assign out_load = (state_q == fsa_pkg::BK_DONE) && (!out_valid_q || !out_stall_i);

  // Classify the head request for result staging
  assign go      = item_i.known && !under && !over;
  assign is_cr   = go && (item_i.cmd == fsa_pkg::CMD_CR);
  assign is_push = go && (item_i.cmd == fsa_pkg::CMD_PUSH);
  assign is_mod  = (cmd_q == fsa_pkg::CMD_MOD);

  // Multiply partial product and shifted accumulate term
  assign xs     = step_q[0] ? x_q[63:32] : x_q[31:0];
  assign ys     = step_q[1] ? y_q[63:32] : y_q[31:0];
  assign prod   = {32'd0, xs} * {32'd0, ys};
  assign ppw    = {64'd0, pp_q} << {psel_q[0] & psel_q[1], psel_q[0] ^ psel_q[1], 5'd0};
  assign acc_sh = acc_q >> fsa_pkg::FRAC_BITS;

  // Restoring divide step
  assign rw   = {rem_q, num_q[127]};
  assign ge   = (rw >= {1'b0, den_q});
  assign rsub = rw - {1'b0, den_q};
  assign ipa  = a_q[63] ? (64'd0 - fsa_pkg::fx_int_mag(a_q)) : fsa_pkg::fx_int_mag(a_q);
  assign rm   = rem_q << fsa_pkg::FRAC_BITS;

  // Next state, RAM addressing and queue pop
  always_comb begin
    state_d    = state_q;
    item_pop_o = 1'b0;
    raddr      = cm3[AW-1:0];
    we         = 1'b0;
    waddr      = cm2[AW-1:0];
    wdata      = res_val_q;
    last_wr    = 1'b1;
    case (state_q)
      fsa_pkg::BK_IDLE: begin
        raddr = cm1[AW-1:0];
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          if (!item_i.known || under || over || item_i.cmd == fsa_pkg::CMD_CR) begin
            state_d = fsa_pkg::BK_DONE;
          end else if (item_i.cmd == fsa_pkg::CMD_PUSH) begin
            state_d = fsa_pkg::BK_WR;
          end else begin
            state_d = fsa_pkg::BK_RDA;
          end
        end
      end
      fsa_pkg::BK_RDA: begin
        raddr   = cm2[AW-1:0];
        state_d = fsa_pkg::BK_RDB;
      end
      fsa_pkg::BK_RDB: begin
        raddr   = cm3[AW-1:0];
        state_d = fsa_pkg::BK_RDC;
      end
      fsa_pkg::BK_RDC: begin
        case (cmd_q) inside
          fsa_pkg::CMD_ADD, fsa_pkg::CMD_SUB, [fsa_pkg::CMD_LT:fsa_pkg::CMD_EQ],
          [fsa_pkg::CMD_DUP:fsa_pkg::CMD_OVER]:
            state_d = fsa_pkg::BK_WR;
          fsa_pkg::CMD_MUL: state_d = fsa_pkg::BK_MUL;
          fsa_pkg::CMD_DIV:
            state_d = (a_q == 64'd0) ? fsa_pkg::BK_DONE : fsa_pkg::BK_DIV;
          fsa_pkg::CMD_MOD:
            state_d = am_zero ? fsa_pkg::BK_DONE : fsa_pkg::BK_DIV;
          default: state_d = fsa_pkg::BK_DONE;
        endcase
      end
      fsa_pkg::BK_MUL: begin
        if (step_q == 7'd4) state_d = fsa_pkg::BK_MULSAT;
      end
      fsa_pkg::BK_MULSAT: state_d = fsa_pkg::BK_WR;
      fsa_pkg::BK_DIV: begin
        if (step_q == '1) state_d = fsa_pkg::BK_DIVFIN;
      end
      fsa_pkg::BK_DIVFIN: state_d = fsa_pkg::BK_WR;
      fsa_pkg::BK_WR: begin
        we = 1'b1;
        case (cmd_q)
          fsa_pkg::CMD_PUSH: begin
            waddr = cnt_q[AW-1:0];
            wdata = lit_q;
          end
          fsa_pkg::CMD_DUP: begin
            waddr = cnt_q[AW-1:0];
            wdata = a_q;
          end
          fsa_pkg::CMD_OVER: begin
            waddr = cnt_q[AW-1:0];
            wdata = b_q;
          end
          fsa_pkg::CMD_SWAP: begin
            last_wr = (step_q == 7'd1);
            waddr   = (step_q == 7'd0) ? cm1[AW-1:0] : cm2[AW-1:0];
            wdata   = (step_q == 7'd0) ? b_q : a_q;
          end
          fsa_pkg::CMD_ROT: begin
            last_wr = (step_q == 7'd2);
            case (step_q)
              7'd0: begin
                waddr = cm3[AW-1:0];
                wdata = b_q;
              end
              7'd1: begin
                waddr = cm2[AW-1:0];
                wdata = a_q;
              end
              default: begin
                waddr = cm1[AW-1:0];
                wdata = c_q;
              end
            endcase
          end
          default: begin
            waddr = cm2[AW-1:0];
            wdata = res_val_q;
          end
        endcase
        if (last_wr) state_d = fsa_pkg::BK_DONE;
      end
      fsa_pkg::BK_DONE: begin
        if (out_load) state_d = fsa_pkg::BK_IDLE;
      end
      default: state_d = fsa_pkg::BK_IDLE;
    endcase
  end

  // State and stack count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fsa_pkg::BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        cnt_q       <= res_cnt_q;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath: operands, multiply, divide, result staging
  always_ff @(posedge clk_i) begin
    case (state_q)
      fsa_pkg::BK_IDLE: begin
        step_q     <= '0;
        cmd_q      <= fsa_pkg::fsa_cmd_e'(item_i.cmd);
        lit_q      <= item_i.lit;
        res_num_q  <= '0;
        res_kind_q <= is_cr ? fsa_pkg::KIND_CHAR : fsa_pkg::KIND_NONE;
        res_char_q <= is_cr ? fsa_pkg::CHAR_NL : 8'd0;
        res_cnt_q  <= is_push ? (cnt_q + CW'(1)) : cnt_q;
        if (!item_i.known) begin
          res_err_q <= fsa_pkg::ERR_NONE;
        end else if (under) begin
          res_err_q <= fsa_pkg::ERR_UNDER;
        end else if (over) begin
          res_err_q <= fsa_pkg::ERR_OVER;
        end else begin
          res_err_q <= fsa_pkg::ERR_NONE;
        end
      end
      fsa_pkg::BK_RDA: a_q <= rdata;
      fsa_pkg::BK_RDB: b_q <= rdata;
      fsa_pkg::BK_RDC: begin
        c_q    <= rdata;
        step_q <= '0;
        acc_q  <= '0;
        rem_q  <= '0;
        quo_q  <= '0;
        x_q    <= fsa_pkg::fx_mag(b_q);
        y_q    <= fsa_pkg::fx_mag(a_q);
        // Mod divides integer parts; div divides the scaled magnitude
        neg_q  <= is_mod ? b_q[63] : (a_q[63] ^ b_q[63]);
        den_q  <= is_mod ? fsa_pkg::fx_int_mag(a_q) : fsa_pkg::fx_mag(a_q);
        num_q  <= is_mod ? {64'd0, fsa_pkg::fx_int_mag(b_q)}
                         : ({64'd0, fsa_pkg::fx_mag(b_q)} << fsa_pkg::FRAC_BITS);
        case (cmd_q)
          fsa_pkg::CMD_ADD: begin
            res_val_q <= b_q + a_q;
            res_cnt_q <= cm1;
          end
          fsa_pkg::CMD_SUB: begin
            res_val_q <= b_q - a_q;
            res_cnt_q <= cm1;
          end
          fsa_pkg::CMD_LT: begin
            res_val_q <= ($signed(b_q) < $signed(a_q)) ? fsa_pkg::FX_ONE : 64'd0;
            res_cnt_q <= cm1;
          end
          fsa_pkg::CMD_GT: begin
            res_val_q <= ($signed(a_q) < $signed(b_q)) ? fsa_pkg::FX_ONE : 64'd0;
            res_cnt_q <= cm1;
          end
          fsa_pkg::CMD_EQ: begin
            res_val_q <= (a_q == b_q) ? fsa_pkg::FX_ONE : 64'd0;
            res_cnt_q <= cm1;
          end
          fsa_pkg::CMD_DIV: begin
            if (a_q == 64'd0) res_err_q <= fsa_pkg::ERR_DIV0;
          end
          fsa_pkg::CMD_MOD: begin
            if (am_zero) res_err_q <= fsa_pkg::ERR_DIV0;
          end
          fsa_pkg::CMD_PRINT: begin
            res_kind_q <= fsa_pkg::KIND_NUM;
            res_num_q  <= a_q;
            res_cnt_q  <= cm1;
          end
          fsa_pkg::CMD_DROP: res_cnt_q <= cm1;
          fsa_pkg::CMD_EMIT: begin
            res_kind_q <= fsa_pkg::KIND_CHAR;
            res_char_q <= ipa[7:0];
            res_cnt_q  <= cm1;
          end
          fsa_pkg::CMD_DUP, fsa_pkg::CMD_OVER: res_cnt_q <= cnt_q + CW'(1);
          default: res_cnt_q <= res_cnt_q;
        endcase
      end
      fsa_pkg::BK_MUL: begin
        step_q <= step_q + 7'd1;
        pp_q   <= prod;
        psel_q <= step_q[1:0];
        if (step_q != 7'd0) acc_q <= acc_q + ppw;
      end
      fsa_pkg::BK_MULSAT: begin
        step_q    <= '0;
        res_val_q <= fsa_pkg::fx_sat(acc_sh[127:64], acc_sh[63:0], neg_q);
        res_cnt_q <= cm1;
      end
      fsa_pkg::BK_DIV: begin
        step_q <= step_q + 7'd1;
        rem_q  <= ge ? rsub[63:0] : rw[63:0];
        quo_q  <= {quo_q[126:0], ge};
        num_q  <= num_q << 1;
      end
      fsa_pkg::BK_DIVFIN: begin
        step_q    <= '0;
        res_cnt_q <= cm1;
        if (cmd_q == fsa_pkg::CMD_MOD) begin
          res_val_q <= neg_q ? (64'd0 - rm) : rm;
        end else begin
          res_val_q <= fsa_pkg::fx_sat(quo_q[127:64], quo_q[63:0], neg_q);
        end
      end
      fsa_pkg::BK_WR: step_q <= step_q + 7'd1;
      default: step_q <= step_q;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q  <= res_kind_q;
      out_num_q   <= res_num_q;
      out_char_q  <= res_char_q;
      out_err_q   <= res_err_q;
      out_depth_q <= 7'(res_cnt_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign out_number_o = out_num_q;
  assign out_char_o   = out_char_q;
  assign error_o      = out_err_q;
  assign depth_now_o  = out_depth_q;

endmodule

// ----- rtl/core/forth_stack_alu.sv -----
// ----------------------------------------------------------------------------
// forth_stack_alu
// Forth data stack of signed Q32.32 values with an arithmetic unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one word per request:
//   command_i and, for push, literal_i. Output channel (out_valid_o /
//   out_stall_i) returns exactly one result per request: kind, printed
//   number, emitted char, error code and the stack depth afterwards.
//   A two-entry queue sits between the front and the execution unit, so
//   requests are taken while a result waits in the output register.
//   After the queue hands over a word, cr, stack errors and unknown codes go
//   straight to the result; push writes the stack; the stack, add/sub/compare,
//   print, emit and division-by-zero words first read their operands; mul
//   then sums four 32x32 partial products, and div and mod run the
//   one-bit-per-cycle restoring divider over 128 quotient bits.
//   One word executes at a time; the next starts the cycle after a result
//   is loaded, so no new request starts before the last one's result.
//   Reset empties the queue and the stack count and drops any pending
//   result; stack RAM contents are not cleared.
//   A stalled result holds its fields; a finished word waits in the done
//   state until the output register is free.
// ----------------------------------------------------------------------------
module forth_stack_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  command_i,
  input  logic [63:0] literal_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_kind_o,
  output logic [63:0] out_number_o,
  output logic [7:0]  out_char_o,
  output logic [1:0]  error_o,
  output logic [6:0]  depth_now_o
);

  fsa_pkg::fsa_item_t item;
  logic               item_valid, item_pop;

  fsa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .literal_i    (literal_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  fsa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_kind_o   (out_kind_o),
    .out_number_o (out_number_o),
    .out_char_o   (out_char_o),
    .error_o      (error_o),
    .depth_now_o  (depth_now_o)
  );

endmodule

// ----- rtl/core/fsa_checker.sv -----
// ----------------------------------------------------------------------------
// fsa_checker
// Port-level checks on results of the Forth stack ALU.
// ----------------------------------------------------------------------------
module fsa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [4:0]  command_i,
  input logic [63:0] literal_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  out_kind_o,
  input logic [63:0] out_number_o,
  input logic [7:0]  out_char_o,
  input logic [1:0]  error_o,
  input logic [6:0]  depth_now_o
);

  // Hold a stalled request
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(command_i) &&
    $stable(literal_i))
    else $error("stalled request changed");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_number_o) &&
    $stable(error_o) && $stable(depth_now_o))
    else $error("stalled result changed");

  // Failed words print nothing
  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_o != fsa_pkg::ERR_NONE) |-> out_kind_o == fsa_pkg::KIND_NONE)
    else $error("error with output");

  // Printed number carries no char
  a_num_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o == fsa_pkg::KIND_NUM) |-> out_char_o == 8'd0)
    else $error("char on print");

  // Overflow only on a full stack
  a_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_o == fsa_pkg::ERR_OVER) |->
    depth_now_o == 7'(fsa_pkg::STACK_DEPTH))
    else $error("overflow below full depth");

endmodule

bind forth_stack_alu fsa_checker u_fsa_checker (.*);

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Random and directed test of the Forth stack ALU: a local stack model
// predicts every result, a scoreboard compares them field by field.
// ----------------------------------------------------------------------------
class fsa_scoreboard;
  typedef struct {
    logic [1:0]  kind;
    logic [63:0] num;
    logic [7:0]  ch;
    logic [1:0]  err;
    logic [6:0]  depth;
  } fsa_res_t;

  logic [63:0] stk [64];
  int unsigned cnt;
  fsa_res_t    pending [$];
  int unsigned fails;

  function new();
    cnt = 0;
    fails = 0;
  endfunction

  function automatic logic [63:0] mag(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic logic [63:0] sat(logic [127:0] m, logic neg);
    if (neg) return (m > {64'd0, fsa_pkg::SIGN_BIT}) ? fsa_pkg::SIGN_BIT : -m[63:0];
    return (m > {64'd0, fsa_pkg::MAX_POS}) ? fsa_pkg::MAX_POS : m[63:0];
  endfunction

  // Work out the result of one accepted request and update the stack
  function void note_request(logic [4:0] cmd, logic [63:0] lit);
    fsa_res_t r;
    int unsigned need;
    bit grows;
    logic [63:0] a, b, c, am, bm;
    logic [127:0] p;
    r = '{default: '0};
    need = 0;
    if (cmd >= fsa_pkg::CMD_ADD && cmd <= fsa_pkg::CMD_EQ) need = 2;
    else if (cmd == fsa_pkg::CMD_PRINT || cmd == fsa_pkg::CMD_DROP ||
             cmd == fsa_pkg::CMD_DUP || cmd == fsa_pkg::CMD_EMIT) need = 1;
    else if (cmd == fsa_pkg::CMD_SWAP || cmd == fsa_pkg::CMD_OVER) need = 2;
    else if (cmd == fsa_pkg::CMD_ROT) need = 3;
    grows = (cmd == fsa_pkg::CMD_PUSH || cmd == fsa_pkg::CMD_DUP ||
             cmd == fsa_pkg::CMD_OVER);
    a = (cnt >= 1) ? stk[cnt-1] : '0;
    b = (cnt >= 2) ? stk[cnt-2] : '0;
    if (cmd > fsa_pkg::CMD_CR) begin
    end else if (cnt < need) begin
      r.err = fsa_pkg::ERR_UNDER;
    end else if (grows && cnt >= 64) begin
      r.err = fsa_pkg::ERR_OVER;
    end else begin
      case (cmd)
        fsa_pkg::CMD_PUSH: begin stk[cnt] = lit; cnt++; end
        fsa_pkg::CMD_ADD:  begin stk[cnt-2] = b + a; cnt--; end
        fsa_pkg::CMD_SUB:  begin stk[cnt-2] = b - a; cnt--; end
        fsa_pkg::CMD_MUL: begin
          p = {64'd0, mag(b)} * {64'd0, mag(a)};
          stk[cnt-2] = sat(p >> 32, a[63] ^ b[63]); cnt--;
        end
        fsa_pkg::CMD_DIV: begin
          if (a == 0) r.err = fsa_pkg::ERR_DIV0;
          else begin
            p = ({64'd0, mag(b)} << 32) / {64'd0, mag(a)};
            stk[cnt-2] = sat(p, a[63] ^ b[63]); cnt--;
          end
        end
        fsa_pkg::CMD_MOD: begin
          am = mag(a) >> 32;
          bm = mag(b) >> 32;
          if (am == 0) r.err = fsa_pkg::ERR_DIV0;
          else begin
            c = (bm % am) << 32;
            stk[cnt-2] = b[63] ? -c : c; cnt--;
          end
        end
        fsa_pkg::CMD_LT: begin
          stk[cnt-2] = ($signed(b) < $signed(a)) ? fsa_pkg::FX_ONE : '0; cnt--;
        end
        fsa_pkg::CMD_GT: begin
          stk[cnt-2] = ($signed(b) > $signed(a)) ? fsa_pkg::FX_ONE : '0; cnt--;
        end
        fsa_pkg::CMD_EQ: begin stk[cnt-2] = (a == b) ? fsa_pkg::FX_ONE : '0; cnt--; end
        fsa_pkg::CMD_PRINT: begin r.kind = fsa_pkg::KIND_NUM; r.num = a; cnt--; end
        fsa_pkg::CMD_DROP: cnt--;
        fsa_pkg::CMD_DUP:  begin stk[cnt] = a; cnt++; end
        fsa_pkg::CMD_SWAP: begin stk[cnt-1] = b; stk[cnt-2] = a; end
        fsa_pkg::CMD_ROT: begin
          c = stk[cnt-3];
          stk[cnt-3] = b; stk[cnt-2] = a; stk[cnt-1] = c;
        end
        fsa_pkg::CMD_OVER: begin stk[cnt] = b; cnt++; end
        fsa_pkg::CMD_EMIT: begin
          c = mag(a) >> 32;
          if (a[63]) c = -c;
          r.kind = fsa_pkg::KIND_CHAR; r.ch = c[7:0]; cnt--;
        end
        default: begin r.kind = fsa_pkg::KIND_CHAR; r.ch = fsa_pkg::CHAR_NL; end
      endcase
    end
    r.depth = cnt[6:0];
    pending.push_back(r);
  endfunction

  // Compare one result with the oldest expectation
  function void check_result(logic [1:0] kind, logic [63:0] num, logic [7:0] ch,
                             logic [1:0] err, logic [6:0] depth);
    fsa_res_t e;
    if (pending.size() == 0) begin
      $error("result with no request outstanding");
      fails++;
      return;
    end
    e = pending.pop_front();
    if (kind !== e.kind) begin $error("out_kind exp %0d got %0d", e.kind, kind); fails++; end
    if (num !== e.num) begin $error("out_number exp %h got %h", e.num, num); fails++; end
    if (ch !== e.ch) begin $error("out_char exp %0d got %0d", e.ch, ch); fails++; end
    if (err !== e.err) begin $error("error exp %0d got %0d", e.err, err); fails++; end
    if (depth !== e.depth) begin $error("depth_now exp %0d got %0d", e.depth, depth); fails++; end
  endfunction
endclass

module tb_top;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [4:0]  command_i = '0;
  logic [63:0] literal_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  out_kind_o;
  logic [63:0] out_number_o;
  logic [7:0]  out_char_o;
  logic [1:0]  error_o;
  logic [6:0]  depth_now_o;

  fsa_scoreboard sb = new();
  int unsigned cycles = 0;
  bit calm = 1'b0;
  int unsigned model_depth = 0;

  forth_stack_alu u_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog on total run length
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(out_kind_o, out_number_o, out_char_o, error_o, depth_now_o);
  end

  // Stall the result side in random bursts
  initial begin : stall_gen
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 12);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // Offer one request and hold it until taken
  task automatic send_req(logic [4:0] cmd, logic [63:0] lit);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    literal_i  <= lit;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(cmd, lit);
    model_depth = sb.cnt;
  endtask

  function automatic logic [63:0] rand_fx();
    case ($urandom_range(0, 5))
      0: return {$urandom, $urandom};
      1: return {{32{1'b0}}, $urandom} << $urandom_range(0, 40);
      2: return -({32'd0, $urandom} << $urandom_range(0, 40));
      3: return {32'($signed($urandom_range(0, 40)) - 20), 32'd0};
      4: return $urandom_range(0, 1) ? fsa_pkg::MAX_POS : fsa_pkg::SIGN_BIT;
      default: return 64'd0;
    endcase
  endfunction

  initial begin : main
    int unsigned k;
    logic [4:0] cmd;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: underflow on empty, cr, unknown, arithmetic and edges
    send_req(fsa_pkg::CMD_ADD, '0);
    send_req(fsa_pkg::CMD_ROT, '0);
    send_req(fsa_pkg::CMD_CR, '0);
    send_req(5'd31, '1);
    send_req(fsa_pkg::CMD_PUSH, fsa_pkg::MAX_POS);
    send_req(fsa_pkg::CMD_PUSH, fsa_pkg::MAX_POS);
    send_req(fsa_pkg::CMD_MUL, '0);
    send_req(fsa_pkg::CMD_PUSH, fsa_pkg::SIGN_BIT);
    send_req(fsa_pkg::CMD_PUSH, 64'd1);
    send_req(fsa_pkg::CMD_DIV, '0);
    send_req(fsa_pkg::CMD_PUSH, '0);
    send_req(fsa_pkg::CMD_DIV, '0);
    send_req(fsa_pkg::CMD_PUSH, 64'h0000_0000_8000_0000);
    send_req(fsa_pkg::CMD_MOD, '0);
    send_req(fsa_pkg::CMD_PUSH, 64'hFFFF_FFF9_0000_0000);
    send_req(fsa_pkg::CMD_PUSH, 64'h0000_0003_0000_0000);
    send_req(fsa_pkg::CMD_MOD, '0);
    send_req(fsa_pkg::CMD_ROT, '0);
    send_req(fsa_pkg::CMD_OVER, '0);
    send_req(fsa_pkg::CMD_SWAP, '0);
    send_req(fsa_pkg::CMD_LT, '0);
    send_req(fsa_pkg::CMD_EMIT, '0);
    send_req(fsa_pkg::CMD_PRINT, '0);
    // Fill to overflow, then drain
    while (model_depth < 64) send_req(fsa_pkg::CMD_PUSH, {$urandom, $urandom});
    send_req(fsa_pkg::CMD_DUP, '0);
    send_req(fsa_pkg::CMD_OVER, '0);
    send_req(fsa_pkg::CMD_PUSH, '0);
    while (model_depth > 0) send_req(fsa_pkg::CMD_DROP, '0);

    // Random: mostly valid words, with drift in depth
    for (k = 0; k < 1000; k++) begin
      if (k > 850) calm = 1'b1;
      if ($urandom_range(0, 40) == 0) cmd = 5'($urandom_range(17, 31));
      else if (model_depth < 3 && $urandom_range(0, 3) != 0) cmd = fsa_pkg::CMD_PUSH;
      else if (model_depth > 60 && $urandom_range(0, 1) == 0) cmd = fsa_pkg::CMD_DROP;
      else cmd = 5'($urandom_range(0, 16));
      send_req(cmd, rand_fx());
    end
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.fails == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
